/* sv/scfr_pkg.sv */
package scfr_pkg;

  localparam int IdxW      = 6;
  localparam int LimitW    = 7;
  localparam int StatusW   = 3;
  localparam int CfgAddrW  = 3;
  localparam int CfgDataW  = 32;

  localparam logic [LimitW-1:0] LimitReset = 7'd64;

  // register index field of paddr (bits above the byte offset)
  localparam logic [CfgAddrW-3:0] RegFrameLimit = 1'b0;

  localparam logic ActRequest   = 1'b0;
  localparam logic ActReference = 1'b1;

  typedef enum logic [StatusW-1:0] {
    STATUS_NEW    = 3'd0,
    STATUS_REUSED = 3'd1,
    STATUS_NONE   = 3'd2,
    STATUS_REF    = 3'd3,
    STATUS_BAD    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_GRANT = 2'd1,
    OP_REF   = 2'd2,
    OP_SCAN  = 2'd3
  } op_e;

  typedef struct packed {
    op_e  op;
    logic pin;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic found;
  } rsp_t;

endpackage

/* sv/scfr_ifs.sv */
interface scfr_req_if import scfr_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            action;
  logic [IdxW-1:0] frame_index;
  logic            pinned;

  modport source (output valid, action, frame_index, pinned, input ready);
  modport sink   (input valid, action, frame_index, pinned, output ready);
endinterface

interface scfr_rsp_if import scfr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [IdxW-1:0]    granted_frame;

  modport source (output valid, status, granted_frame, input ready);
  modport sink   (input valid, status, granted_frame, output ready);
endinterface

/* sv/scfr_engine.sv */
module scfr_engine import scfr_pkg::*; #(
  parameter int FRAMES = 64,
  localparam int AddrW = $clog2(FRAMES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  logic [AddrW-1:0] addr_i,
  output rsp_t             rsp_o,
  output logic [AddrW-1:0] victim_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [AddrW-1:0] rd_idx_q, rd_idx_d;
  logic             rd_pass_q, rd_pass_d;
  logic             rd_live_q, rd_live_d;
  logic [AddrW-1:0] last_q, last_d;
  logic             pin_q, pin_d;
  logic             ev_vld_q, ev_vld_d;
  logic [AddrW-1:0] ev_idx_q, ev_idx_d;
  logic             ev_last_q, ev_last_d;
  logic             fwd_q, fwd_d;

  logic acc_mem [FRAMES];
  logic pin_mem [FRAMES];
  logic acc_rd_q, pin_rd_q;

  logic             acc_we, acc_wd, pin_we, pin_wd;
  logic [AddrW-1:0] wr_addr;
  logic             acc_eff;
  logic             done, found;

  // entry written last cycle may be the one read in that same cycle
  assign acc_eff = acc_rd_q & ~fwd_q;

  always_comb begin
    state_d   = state_q;
    rd_idx_d  = rd_idx_q;
    rd_pass_d = rd_pass_q;
    rd_live_d = rd_live_q;
    last_d    = last_q;
    pin_d     = pin_q;
    ev_vld_d  = 1'b0;
    ev_idx_d  = ev_idx_q;
    ev_last_d = 1'b0;
    fwd_d     = 1'b0;
    acc_we    = 1'b0;
    acc_wd    = 1'b0;
    pin_we    = 1'b0;
    pin_wd    = 1'b0;
    wr_addr   = addr_i;
    done      = 1'b0;
    found     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        unique case (cmd_i.op)
          OP_GRANT: begin
            acc_we = 1'b1;
            pin_we = 1'b1;
            pin_wd = cmd_i.pin;
          end
          OP_REF: begin
            acc_we = 1'b1;
            acc_wd = 1'b1;
          end
          OP_SCAN: begin
            state_d   = ST_SCAN;
            rd_idx_d  = '0;
            rd_pass_d = 1'b0;
            rd_live_d = 1'b1;
            last_d    = addr_i;
            pin_d     = cmd_i.pin;
          end
          OP_NONE: ;
        endcase
      end
      ST_SCAN: begin
        // read side: one entry per cycle, up to two passes
        ev_vld_d  = rd_live_q;
        ev_idx_d  = rd_idx_q;
        ev_last_d = rd_pass_q && (rd_idx_q == last_q);
        if (rd_live_q) begin
          if (rd_idx_q == last_q) begin
            rd_idx_d = '0;
            if (rd_pass_q) rd_live_d = 1'b0;
            else           rd_pass_d = 1'b1;
          end else begin
            rd_idx_d = rd_idx_q + AddrW'(1);
          end
        end
        // evaluate side: entry read in the previous cycle
        wr_addr = ev_idx_q;
        if (ev_vld_q) begin
          if (!pin_rd_q && !acc_eff) begin
            acc_we  = 1'b1;
            pin_we  = 1'b1;
            pin_wd  = pin_q;
            done    = 1'b1;
            found   = 1'b1;
            ev_vld_d = 1'b0;
            state_d = ST_IDLE;
          end else begin
            if (!pin_rd_q) begin
              acc_we = 1'b1;
              fwd_d  = rd_live_q && (rd_idx_q == ev_idx_q);
            end
            if (ev_last_q) begin
              done     = 1'b1;
              ev_vld_d = 1'b0;
              state_d  = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) acc_mem[wr_addr] <= acc_wd;
    if (pin_we) pin_mem[wr_addr] <= pin_wd;
    acc_rd_q <= acc_mem[rd_idx_q];
    pin_rd_q <= pin_mem[rd_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_live_q <= 1'b0;
      rd_pass_q <= 1'b0;
      ev_vld_q  <= 1'b0;
      ev_last_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_live_q <= rd_live_d;
      rd_pass_q <= rd_pass_d;
      ev_vld_q  <= ev_vld_d;
      ev_last_q <= ev_last_d;
      fwd_q     <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    last_q   <= last_d;
    pin_q    <= pin_d;
    ev_idx_q <= ev_idx_d;
  end

  assign rsp_o.busy  = (state_q == ST_SCAN);
  assign rsp_o.done  = done;
  assign rsp_o.found = found;
  assign victim_o    = ev_idx_q;

endmodule

/* sv/second_chance_frame_replacer.sv */
// channel | dir | handshake      | payload
// req_i   | in  | valid / ready  | action, frame_index, pinned
// rsp_o   | out | valid / ready  | status, granted_frame
// apb     | in  | psel / penable | frame_limit at byte address 0
//
// References and new-frame grants: result registered at acceptance.
// Eviction scan: reads the frame table memory one entry per cycle over up to two
// passes.
// Reset clears control state and the frame count; table entries past the count are
// never read, so no clearing pass is needed.
// A result waiting on rsp_o holds off the next request until it is taken.
module second_chance_frame_replacer import scfr_pkg::*; #(
  parameter int FRAMES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  scfr_req_if.sink            req_i,
  scfr_rsp_if.source          rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  localparam int AddrW = $clog2(FRAMES);
  localparam int CntW  = $clog2(FRAMES + 1);
  localparam int CmpW  = (CntW > LimitW) ? CntW : LimitW;

  logic [LimitW-1:0]  limit_q;
  logic [CntW-1:0]    used_q;
  logic               out_vld_q;
  status_e            out_status_q;
  logic [IdxW-1:0]    out_frame_q;

  cmd_t               eng_cmd;
  rsp_t               eng_rsp;
  logic [AddrW-1:0]   eng_addr;
  logic [AddrW-1:0]   victim;

  logic               accept, take;
  logic [CmpW-1:0]    used_ext, used_m1, idx_ext, lim_ext, lim_eff, victim_ext;
  logic               imm_vld;
  status_e            imm_status;
  logic [IdxW-1:0]    imm_frame;
  logic               grow;
  logic               cfg_we;

  assign cfg_we = psel && penable && pwrite && (paddr[CfgAddrW-1:2] == RegFrameLimit);
  assign prdata = (paddr[CfgAddrW-1:2] == RegFrameLimit) ? CfgDataW'(limit_q) : '0;
  assign pready = 1'b1;

  assign req_i.ready = !eng_rsp.busy && (!out_vld_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign take        = rsp_o.valid && rsp_o.ready;

  assign used_ext   = CmpW'(used_q);
  assign used_m1    = used_ext - CmpW'(1);
  assign idx_ext    = CmpW'(req_i.frame_index);
  assign lim_ext    = CmpW'(limit_q);
  assign lim_eff    = (lim_ext > CmpW'(FRAMES)) ? CmpW'(FRAMES) : lim_ext;
  assign victim_ext = CmpW'(victim);

  always_comb begin
    eng_cmd.op  = OP_NONE;
    eng_cmd.pin = req_i.pinned;
    eng_addr    = used_ext[AddrW-1:0];
    imm_vld     = 1'b0;
    imm_status  = STATUS_NONE;
    imm_frame   = '0;
    grow        = 1'b0;
    if (accept) begin
      if (req_i.action == ActReference) begin
        imm_vld = 1'b1;
        if (idx_ext < used_ext) begin
          eng_cmd.op = OP_REF;
          eng_addr   = idx_ext[AddrW-1:0];
          imm_status = STATUS_REF;
        end else begin
          imm_status = STATUS_BAD;
        end
      end else if (used_ext < lim_eff) begin
        eng_cmd.op = OP_GRANT;
        imm_vld    = 1'b1;
        imm_status = STATUS_NEW;
        imm_frame  = used_ext[IdxW-1:0];
        grow       = 1'b1;
      end else if (used_q == '0) begin
        imm_vld    = 1'b1;
        imm_status = STATUS_NONE;
      end else begin
        eng_cmd.op = OP_SCAN;
        eng_addr   = used_m1[AddrW-1:0];
      end
    end
  end

  scfr_engine #(.FRAMES(FRAMES)) u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (eng_cmd),
    .addr_i  (eng_addr),
    .rsp_o   (eng_rsp),
    .victim_o(victim)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= LimitReset;
      used_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we) limit_q <= pwdata[LimitW-1:0];
      if (grow)   used_q  <= used_q + CntW'(1);
      if (imm_vld || eng_rsp.done) out_vld_q <= 1'b1;
      else if (take)               out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (imm_vld) begin
      out_status_q <= imm_status;
      out_frame_q  <= imm_frame;
    end else if (eng_rsp.done) begin
      out_status_q <= eng_rsp.found ? STATUS_REUSED : STATUS_NONE;
      out_frame_q  <= eng_rsp.found ? victim_ext[IdxW-1:0] : '0;
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.granted_frame = out_frame_q;

endmodule

/* sv/scfr_checker.sv */
module scfr_checker import scfr_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               in_action_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [StatusW-1:0] out_status_i,
  input logic [IdxW-1:0]    out_frame_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // no new transaction taken while a result is stuck
  a_no_accept_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("request accepted behind a stalled result");

  // references answer in the next cycle
  a_ref_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_action_i == ActReference) |=>
      out_valid_i && (out_status_i == STATUS_REF || out_status_i == STATUS_BAD))
    else $error("reference result missing");

  // only grants and reuses carry a frame number
  a_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == STATUS_NONE || out_status_i == STATUS_REF ||
                    out_status_i == STATUS_BAD) |-> out_frame_i == '0)
    else $error("frame number on a non-grant result");

endmodule

bind second_chance_frame_replacer scfr_checker u_scfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .in_action_i (req_i.action),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_status_i(rsp_o.status),
  .out_frame_i (rsp_o.granted_frame)
);
